@@ rtl/core/msb_pkg.sv @@
// Shared request codes, mask type and heart sprite bitmaps for the sprite blitter.
package msb_pkg;

	typedef logic [1:0] req_t;

	localparam req_t REQ_FILL    = 2'd0;
	localparam req_t REQ_OUTLINE = 2'd1;
	localparam req_t REQ_CLEAR   = 2'd2;
	localparam req_t REQ_READ    = 2'd3;

	localparam int COL_W    = 4;
	localparam int ROM_ROWS = 13;

	typedef struct packed {
		logic [7:0] clr;
		logic [7:0] set;
	} msb_mask_t;

	localparam logic [15:0] FILLED_ROM [ROM_ROWS] = '{
		16'h1E3C, 16'h3F7E, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h3FFE,
		16'h1FFC, 16'h0FF8, 16'h07F0, 16'h03E0, 16'h01C0, 16'h0080
	};

	localparam logic [15:0] OUTLINE_ROM [ROM_ROWS] = '{
		16'h1E3C, 16'h2142, 16'h4081, 16'h4001, 16'h4001, 16'h4001, 16'h2002,
		16'h1004, 16'h0808, 16'h0410, 16'h0220, 16'h0140, 16'h0080
	};

	// Sprite row bits, MSB is the leftmost column; rows past the bitmap are empty.
	function automatic logic [15:0] heart_row(input logic outline, input logic [7:0] r);
		logic [15:0] v;
		v = '0;
		if (r < 8'(ROM_ROWS)) begin
			v = outline ? OUTLINE_ROM[r[3:0]] : FILLED_ROM[r[3:0]];
		end
		return v;
	endfunction

endpackage

@@ rtl/core/mono_sprite_blitter_core.sv @@
// Top level of the monochrome sprite blitter: request sequencer, framebuffer memory, read port.
//
// Draws 16x13 one-bit heart sprites (filled or outline) into a paged monochrome
// framebuffer held in one synchronous RAM of PAGE_COUNT*DISPLAY_WIDTH bytes
// (byte = page*DISPLAY_WIDTH + column, bit n = row page*8+n). A draw item clears
// the sprite area then sets the sprite pixels; a clear item only clears the area;
// a read item returns one byte on the output channel (0 for an index past the
// store). Positions wrap modulo 256 and off-screen pixels are left alone.
// After reset the block sweeps the whole RAM to zero, one byte per cycle,
// and holds in_stall high meanwhile. Items are handled one at a time. A draw
// or clear walks every page of each of the area's columns through a two-stage
// read-modify-write on the RAM, reading one byte after another through the
// single RAM read port. A read issues its RAM read, waits for the data and
// loads the result register; it is held until the previous result has been
// taken, as one result register sits on the output. Draws and clears go on
// while a result waits to be taken.
module mono_sprite_blitter_core #(
	parameter int DISPLAY_WIDTH  = 128,
	parameter int DISPLAY_HEIGHT = 32,
	parameter int SPRITE_ROWS    = 13,
	parameter int SPRITE_COLS    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  msb_pkg::req_t       req_type,
	input  logic [7:0]          pos_x,
	input  logic [7:0]          pos_y,
	input  logic [8:0]          read_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          read_data
);
	import msb_pkg::*;

	localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_SIZE = PAGE_COUNT * DISPLAY_WIDTH;
	localparam int AW         = $clog2(STORE_SIZE);
	localparam int PW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

	// sequencer states
	localparam logic [2:0] ST_CLR    = 3'd0;  // power-up sweep
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_RUN    = 3'd2;  // area walk
	localparam logic [2:0] ST_READ   = 3'd3;  // waiting for a free result slot
	localparam logic [2:0] ST_RDWAIT = 3'd4;  // RAM data on its way

	logic [2:0]       state_q;
	logic [AW-1:0]    clr_q;
	req_t             kind_q;
	logic [7:0]       x_q;
	logic [7:0]       y_q;
	logic [8:0]       ridx_q;
	logic [COL_W-1:0] col_q;
	logic [PW-1:0]    page_q;
	logic             oor_q;

	// framebuffer
	logic [7:0]    mem [STORE_SIZE];
	logic [7:0]    mem_rdata;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;

	// write-back stage
	logic             valid_s1;
	logic             on_s1;
	logic [AW-1:0]    addr_s1;
	logic [COL_W-1:0] col_s1;
	logic [PW-1:0]    page_s1;

	logic          out_vld_q;
	logic [7:0]    rdata_q;

	logic          in_acc;
	logic [7:0]    px;
	logic          px_on;
	logic [AW-1:0] walk_addr;
	logic          last_page;
	logic          last_col;
	msb_mask_t     mask;

	assign in_stall = (state_q != ST_IDLE) || valid_s1;
	assign in_acc   = in_valid && !in_stall;

	assign px        = x_q + 8'(col_q);
	assign px_on     = int'(px) < DISPLAY_WIDTH;
	assign walk_addr = AW'(int'(page_q) * DISPLAY_WIDTH + int'(px));
	assign last_page = page_q == PW'(PAGE_COUNT - 1);
	assign last_col  = col_q == COL_W'(SPRITE_COLS - 1);

	// RAM read port: area walk or a byte read
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = walk_addr;
		if (state_q == ST_RUN) begin
			rd_en = 1'b1;
		end else if (state_q == ST_READ && !out_vld_q) begin
			rd_en   = 1'b1;
			rd_addr = AW'(ridx_q);
		end
	end

	msb_mask_gen #(
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT),
		.SPRITE_ROWS   (SPRITE_ROWS),
		.PAGE_W        (PW)
	) u_mask (
		.col     (col_s1),
		.page    (page_s1),
		.pos_y   (y_q),
		.req_type(kind_q),
		.mask    (mask)
	);

	// RAM write port: sweep after reset, else write-back of the modified byte
	always_comb begin
		if (state_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = valid_s1 && on_s1;
			wr_addr = addr_s1;
			wr_data = (mem_rdata & ~mask.clr) | mask.set;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rdata <= mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			col_q   <= '0;
			page_q  <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STORE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					col_q  <= '0;
					page_q <= '0;
					if (in_acc) begin
						state_q <= (req_type == REQ_READ) ? ST_READ : ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_page) begin
						page_q <= '0;
						col_q  <= col_q + COL_W'(1);
						if (last_col) begin
							state_q <= ST_IDLE;
						end
					end else begin
						page_q <= page_q + PW'(1);
					end
				end
				ST_READ: begin
					if (!out_vld_q) begin
						state_q <= ST_RDWAIT;
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= req_type;
			x_q    <= pos_x;
			y_q    <= pos_y;
			ridx_q <= read_index;
		end
		if (state_q == ST_READ && !out_vld_q) begin
			oor_q <= int'(ridx_q) >= STORE_SIZE;
		end
	end

	// write-back stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= state_q == ST_RUN;
		end
	end

	always_ff @(posedge clk) begin
		on_s1   <= px_on;
		addr_s1 <= walk_addr;
		col_s1  <= col_q;
		page_s1 <= page_q;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_RDWAIT) begin
			out_vld_q <= 1'b1;
		end else if (out_vld_q && !out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RDWAIT) begin
			rdata_q <= oor_q ? 8'h00 : mem_rdata;
		end
	end

	assign out_valid = out_vld_q;
	assign read_data = rdata_q;

	// no item taken while the sweep runs
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !in_acc)
		else $error("item accepted during RAM sweep");

	// a read result always lands in the result register
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDWAIT) |=> out_vld_q)
		else $error("read result lost");

	// the result slot is free whenever a byte read is issued
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDWAIT) |-> !out_vld_q)
		else $error("result register overwritten");

	// walk never reads the byte being written back
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && px_on && valid_s1 && on_s1) |-> (walk_addr != addr_s1))
		else $error("read-modify-write overlap on one byte");

endmodule

@@ rtl/core/msb_mask_gen.sv @@
// Clear and set masks for one framebuffer byte of a sprite column.
module msb_mask_gen #(
	parameter int DISPLAY_HEIGHT = 32,
	parameter int SPRITE_ROWS    = 13,
	parameter int PAGE_W         = 2
) (
	input  logic [msb_pkg::COL_W-1:0] col,
	input  logic [PAGE_W-1:0]         page,
	input  logic [7:0]                pos_y,
	input  msb_pkg::req_t             req_type,
	output msb_pkg::msb_mask_t        mask
);
	import msb_pkg::*;

	logic        draw;
	logic [3:0]  bsel;

	assign draw = (req_type == REQ_FILL) || (req_type == REQ_OUTLINE);
	assign bsel = ~col;  // bit 15 - col

	always_comb begin
		int         row;
		logic [7:0] rel;
		logic       hit;
		logic [15:0] bits;
		mask = '0;
		for (int n = 0; n < 8; n++) begin
			row  = int'(page) * 8 + n;
			rel  = 8'(row - int'(pos_y));
			hit  = (row < DISPLAY_HEIGHT) && (int'(rel) < SPRITE_ROWS);
			bits = heart_row(req_type == REQ_OUTLINE, rel);
			mask.clr[n] = hit;
			mask.set[n] = hit && draw && bits[bsel];
		end
	end

endmodule

@@ sim/blit_frame_checker.sv @@
// Frame model and read-result checker for the monochrome sprite blitter.
module blit_frame_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  msb_pkg::req_t req_type,
	input  logic [7:0]    pos_x,
	input  logic [7:0]    pos_y,
	input  logic [8:0]    read_index,
	input  logic          out_valid,
	input  logic          out_stall,
	input  logic [7:0]    read_data,
	output int            mismatch_count,
	output int            bytes_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import msb_pkg::*;

	localparam int FB_COLS     = 128;
	localparam int FB_ROWS     = 32;
	localparam int FB_BYTES    = ((FB_ROWS + 7) / 8) * FB_COLS;
	localparam int AREA_ROWS   = 13;
	localparam int AREA_COLS   = 16;
	localparam int BITMAP_ROWS = 13;
	localparam int REPORT_MAX  = 10;

	// MSB of each row is the leftmost column.
	localparam logic [15:0] SOLID_HEART [BITMAP_ROWS] = '{
		16'h1E3C, 16'h3F7E, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h3FFE,
		16'h1FFC, 16'h0FF8, 16'h07F0, 16'h03E0, 16'h01C0, 16'h0080
	};
	localparam logic [15:0] HOLLOW_HEART [BITMAP_ROWS] = '{
		16'h1E3C, 16'h2142, 16'h4081, 16'h4001, 16'h4001, 16'h4001, 16'h2002,
		16'h1004, 16'h0808, 16'h0410, 16'h0220, 16'h0140, 16'h0080
	};

	typedef struct {
		logic [8:0] index;
		logic [7:0] value;
	} fb_read_t;

	logic [7:0] shadow_fb [FB_BYTES];
	fb_read_t   reads_due [$];
	int         errors;

	// One pixel; anything off screen is left alone.
	function automatic void plot(input logic [7:0] px, input logic [7:0] py, input bit on);
		int addr;
		if (px >= FB_COLS || py >= FB_ROWS) return;
		addr = (py / 8) * FB_COLS + px;
		if (addr >= FB_BYTES) return;
		shadow_fb[addr][py[2:0]] = on;
	endfunction

	function automatic void blank_area(input logic [7:0] x, input logic [7:0] y);
		for (int r = 0; r < AREA_ROWS && r < 16; r++)
			for (int c = 0; c < AREA_COLS && c < 16; c++)
				plot(8'(x + c), 8'(y + r), 1'b0);
	endfunction

	function automatic void stamp_heart(input logic [7:0] x, input logic [7:0] y,
			input bit hollow);
		logic [15:0] bits;
		blank_area(x, y);
		for (int r = 0; r < AREA_ROWS && r < BITMAP_ROWS; r++) begin
			bits = hollow ? HOLLOW_HEART[r] : SOLID_HEART[r];
			for (int c = 0; c < AREA_COLS && c < 16; c++)
				if (bits[15 - c]) plot(8'(x + c), 8'(y + r), 1'b1);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fb_read_t due;
		if (!arst_n) begin
			foreach (shadow_fb[i]) shadow_fb[i] = '0;
			reads_due.delete();
			errors = 0;
			mismatch_count <= 0;
			bytes_outstanding <= 0;
		end else begin
			// Result side first: it belongs to an item accepted on an earlier edge.
			if (out_valid && !out_stall) begin
				if (reads_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: unexpected read result %02h", $realtime, read_data);
				end else begin
					due = reads_due.pop_front();
					if (read_data !== due.value) begin
						errors++;
						if (errors <= REPORT_MAX)
							$display("%0t: read of byte %0d: expected %02h, got %02h",
								$realtime, due.index, due.value, read_data);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (req_type)
					REQ_FILL:    stamp_heart(pos_x, pos_y, 1'b0);
					REQ_OUTLINE: stamp_heart(pos_x, pos_y, 1'b1);
					REQ_CLEAR:   blank_area(pos_x, pos_y);
					REQ_READ: begin
						due.index = read_index;
						due.value = (read_index < FB_BYTES) ? shadow_fb[read_index] : 8'h00;
						reads_due.push_back(due);
					end
					default: ;
				endcase
			end
			mismatch_count <= errors;
			bytes_outstanding <= reads_due.size();
		end
	end

endmodule

@@ sim/tb_mono_sprite_blitter_core.sv @@
// Stimulus, reset, watchdog and verdict for the monochrome sprite blitter core.
module tb_mono_sprite_blitter_core;
	timeunit 1ns;
	timeprecision 1ps;
	import msb_pkg::*;

	localparam int RANDOM_ITEMS   = 1930;
	localparam int RX_HOLD_CYCLES = 400;  // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000; // covers the reset sweep and the hold-off
	localparam int SETTLE_CYCLES  = 150;  // lets any last draw finish before the verdict

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	req_t       req_type   = REQ_READ;
	logic [7:0] pos_x      = '0;
	logic [7:0] pos_y      = '0;
	logic [8:0] read_index = '0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] read_data;
	int         mismatch_count;
	int         bytes_outstanding;

	logic       rx_hold_request = 1'b0; // raised by the stimulus, dropped by the receiver
	bit         sender_steady   = 1'b0; // no gaps between items while set
	int         burst_left      = 0;
	logic [7:0] last_x          = '0;   // column of the latest draw, to aim reads at it

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	mono_sprite_blitter_core u_top (
		.clk, .arst_n,
		.in_valid, .in_stall, .req_type, .pos_x, .pos_y, .read_index,
		.out_valid, .out_stall, .read_data
	);

	// Watches both channels, keeps the frame model and counts mismatches.
	blit_frame_checker u_checker (
		.clk, .arst_n,
		.in_valid, .in_stall, .req_type, .pos_x, .pos_y, .read_index,
		.out_valid, .out_stall, .read_data,
		.mismatch_count, .bytes_outstanding
	);

	// Offer one item and return at the edge that accepts it. The sender works
	// in bursts; at the end of a burst it may drop valid for a random gap.
	// Valid is left high on return so back-to-back items keep it asserted.
	task automatic offer_item(input req_t kind, input logic [7:0] x, input logic [7:0] y,
			input logic [8:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (sender_steady || $urandom_range(0, 9) < 4)
				gap = 0;
			else if ($urandom_range(0, 4) == 0)
				gap = $urandom_range(9, 80); // long enough to land anywhere in a draw
			else
				gap = $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		req_type   <= kind;
		pos_x      <= x;
		pos_y      <= y;
		read_index <= idx;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering and wait for every read result to come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (bytes_outstanding != 0);
	endtask

	// Random item: positions mostly on screen, some wrapping past 255, some anywhere.
	// Half the reads aim at columns near the latest draw so they see set pixels.
	task automatic random_item();
		req_t       kind;
		logic [7:0] x;
		logic [7:0] y;
		logic [8:0] idx;
		int         pick;
		pick = $urandom_range(0, 99);
		if (pick < 28)      kind = REQ_FILL;
		else if (pick < 44) kind = REQ_OUTLINE;
		else if (pick < 55) kind = REQ_CLEAR;
		else                kind = REQ_READ;
		case ($urandom_range(0, 3))
			0:       x = 8'($urandom_range(0, 255));
			1:       x = 8'($urandom_range(240, 255));
			default: x = 8'($urandom_range(0, 127));
		endcase
		case ($urandom_range(0, 3))
			0:       y = 8'($urandom_range(0, 255));
			1:       y = 8'($urandom_range(243, 255));
			default: y = 8'($urandom_range(0, 31));
		endcase
		if ($urandom_range(0, 1) == 0)
			idx = 9'($urandom_range(0, 511));
		else
			idx = 9'($urandom_range(0, 3) * 128 + ((last_x + $urandom_range(0, 15)) & 127));
		if (kind == REQ_FILL || kind == REQ_OUTLINE) last_x = x;
		offer_item(kind, x, y, idx);
	endtask

	// Receiver: stall density changes per segment (none up to heavy); on request
	// it holds off for a long stretch so the result register backs up.
	initial begin : rx_pattern
		int stall_pct;
		int segment_left;
		stall_pct = 0;
		segment_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_request) begin
				out_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_request <= 1'b0;
			end
			if (segment_left == 0) begin
				segment_left = $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 30;
					2:       stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			segment_left--;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Ends the run if neither channel moves for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh store reads zero at both ends of the index range.
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd0);
		offer_item(REQ_READ, 8'hFF, 8'hFF, 9'h1FF);
		// Filled heart in the top-left corner, then bytes of pages 0 and 1.
		offer_item(REQ_FILL, 8'd0, 8'd0, 9'd0);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd7);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd135);
		// Clear overlapping part of it; partial bytes must keep the other bits.
		offer_item(REQ_CLEAR, 8'd4, 8'd3, 9'd0);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd7);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd135);
		// Outline heart running off the right and bottom edges.
		offer_item(REQ_OUTLINE, 8'd120, 8'd24, 9'd0);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd504);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd511);
		// Both coordinates wrap past 255 back onto the screen.
		offer_item(REQ_FILL, 8'd250, 8'd250, 9'd0);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd2);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd3);
		// Areas entirely off screen right and below; the third wraps onto the screen.
		offer_item(REQ_OUTLINE, 8'd128, 8'd0, 9'd0);
		offer_item(REQ_FILL, 8'd0, 8'd32, 9'd0);
		offer_item(REQ_OUTLINE, 8'd255, 8'd255, 9'd0);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd0);
		offer_item(REQ_CLEAR, 8'd250, 8'd250, 9'd0);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd2);
		offer_item(REQ_READ, 8'd0, 8'd0, 9'd320);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 500) rx_hold_request <= 1'b1; // sender keeps going meanwhile
			if (n == 900 || n == 1500) drain_results();
			sender_steady = (n >= 1100 && n < 1300);
			random_item();
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && bytes_outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/msb_pkg.sv
rtl/core/msb_mask_gen.sv
rtl/core/mono_sprite_blitter_core.sv
sim/blit_frame_checker.sv
sim/tb_mono_sprite_blitter_core.sv
